// File: hdl/tsil_pkg.sv
// tsil_pkg: request, result and entry types for the sorted timestamp list,
// plus request codes and the seconds weights of the time key.
// No dependencies.
`timescale 1ns / 1ps

package tsil_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // seconds per field unit of the time key
  localparam logic [31:0] SEC_YEAR   = 32'd32140800;
  localparam logic [31:0] SEC_MONTH  = 32'd2678400;
  localparam logic [31:0] SEC_DAY    = 32'd86400;
  localparam logic [31:0] SEC_HOUR   = 32'd3600;
  localparam logic [31:0] SEC_MINUTE = 32'd60;

  localparam int STAMP_W = 42;

  // one request beat
  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic signed [31:0] gain;
    logic [3:0]         read_index;
  } req_t;

  // one result beat
  typedef struct packed {
    logic               accepted;
    logic [3:0]         slot;
    logic [4:0]         fill;
    logic [15:0]        out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic [4:0]         out_hour;
    logic [5:0]         out_minute;
    logic [5:0]         out_second;
    logic signed [31:0] out_gain;
    logic               read_valid;
  } rsp_t;

  // one stored record
  typedef struct packed {
    logic [31:0]        key;
    logic [STAMP_W-1:0] stamp;
    logic [31:0]        gain;
  } entry_t;

endpackage

// File: hdl/tsil_cell.sv
// tsil_cell: one slot of the sorted list; compares the incoming key with its
// own and on insert either keeps, takes its lower neighbor, or takes the new record.
// Depends on tsil_pkg.
`timescale 1ns / 1ps

module tsil_cell (
  input  logic            clk_i,
  input  logic            ins_i,
  input  tsil_pkg::entry_t new_i,
  input  logic            occ_i,
  input  logic            prev_ge_i,
  input  tsil_pkg::entry_t prev_i,
  output logic            ge_o,
  output tsil_pkg::entry_t ent_o
);
  import tsil_pkg::*;

  entry_t ent_q;

  // at or past the insertion point: empty, or holding a strictly larger key
  assign ge_o  = !occ_i || (new_i.key < ent_q.key);
  assign ent_o = ent_q;

  // shift up from the neighbor, or land the new record at the boundary
  always_ff @(posedge clk_i) begin
    if (ins_i && ge_o) begin
      ent_q <= prev_ge_i ? prev_i : new_i;
    end
  end

endmodule

// File: hdl/timestamp_sorted_insert_list.sv
// timestamp_sorted_insert_list: top level, a row of compare-and-shift cells
// holding timestamped gain records in ascending key order.
// Depends on tsil_pkg and tsil_cell.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+---------------------------------
//   request   | start, busy, req_i     | beat taken when start && !busy
//   result    | done_o, rsp_o          | beat valid for the one cycle of done_o
//
// For each request the key is formed and registered with the request on the
// accepting edge, then the cell row compares and shifts as the result beat is
// registered, and the result beat is then shown. busy is high for the one
// cycle between, so a new request can be taken while the result is shown.
// rst_ni empties the list; cell contents are left as they are.
// The receiver cannot stall: each result beat is taken when shown.
`timescale 1ns / 1ps

module timestamp_sorted_insert_list #(
  parameter int CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tsil_pkg::req_t req_i,
  output logic           done_o,
  output tsil_pkg::rsp_t rsp_o
);
  import tsil_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             pend_q;
  req_t             req_q;
  logic [31:0]      key_q;
  logic [31:0]      key_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             done_q;
  rsp_t             rsp_q;
  rsp_t             rsp_d;

  logic             full;
  logic             ins;
  entry_t           new_ent;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ge;
  entry_t           ent [CAPACITY];
  logic [3:0]       slot;
  entry_t           rd_ent;
  logic             rd_hit;

  // time key from the request fields, wrapping at 32 bits
  always_comb begin
    key_d = 32'(req_i.year) * SEC_YEAR
          + 32'(req_i.month) * SEC_MONTH
          + 32'(req_i.day) * SEC_DAY
          + 32'(req_i.hour) * SEC_HOUR
          + 32'(req_i.minute) * SEC_MINUTE
          + 32'(req_i.second);
  end

  assign busy    = pend_q;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign ins     = pend_q && (req_q.req_type == REQ_INSERT) && !full;
  assign new_ent = '{key:   key_q,
                     stamp: {req_q.year, req_q.month, req_q.day,
                             req_q.hour, req_q.minute, req_q.second},
                     gain:  req_q.gain};

  // occupancy of each cell from the fill count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (count_q > CNT_W'(i));
    end
  end

  // row of cells, each but the first fed by its lower neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      tsil_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins),
        .new_i     (new_ent),
        .occ_i     (occ[g]),
        .prev_ge_i (1'b0),
        .prev_i    (new_ent),
        .ge_o      (ge[g]),
        .ent_o     (ent[g])
      );
    end else begin : g_body
      tsil_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins),
        .new_i     (new_ent),
        .occ_i     (occ[g]),
        .prev_ge_i (ge[g-1]),
        .prev_i    (ent[g-1]),
        .ge_o      (ge[g]),
        .ent_o     (ent[g])
      );
    end
  end

  // insertion slot: the cell where the ge flags turn on
  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ge[i] && !((i > 0) && ge[(i > 0) ? i - 1 : 0])) begin
        slot = slot | 4'(i);
      end
    end
  end

  // read select across the row
  always_comb begin
    rd_ent = '0;
    rd_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((int'(req_q.read_index) == i) && occ[i]) begin
        rd_ent = ent[i];
        rd_hit = 1'b1;
      end
    end
  end

  // result beat and next fill count
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (!full) begin
          rsp_d.accepted = 1'b1;
          rsp_d.slot     = slot;
          count_d        = count_q + CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (rd_hit) begin
          {rsp_d.out_year, rsp_d.out_month, rsp_d.out_day,
           rsp_d.out_hour, rsp_d.out_minute, rsp_d.out_second} = rd_ent.stamp;
          rsp_d.out_gain   = rd_ent.gain;
          rsp_d.read_valid = 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    rsp_d.fill = 5'(count_d);
  end

  // control: request stage, fill count, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      pend_q <= start && !pend_q;
      done_q <= pend_q;
      if (pend_q) begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !pend_q) begin
      req_q <= req_i;
      key_q <= key_d;
    end
    if (pend_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
